### hw/rtl/ccrc_pkg.sv
// ----------------------------------------------------------------------------
// ccrc_pkg: shared types and helpers for the configurable CRC engine
// Word layouts of both channels, register indexes, reset values and the
// byte-wide CRC update used by the datapath.
// ----------------------------------------------------------------------------
package ccrc_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_INPUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUTPUT = 2'd3;

    // Width selector codes; the unused code behaves as 32 bits
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h0000_0031;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } ccrc_in_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             config_error;
    } ccrc_out_t;

    function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] reverse_word(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // Move a right-aligned value of the selected width to the top of the word;
    // bits above the width fall off, which also applies the width mask.
    function automatic logic [CRC_W-1:0] align_msb(input logic [CRC_W-1:0] v,
                                                   input logic [1:0]       wsel);
        logic [CRC_W-1:0] r;
        case (wsel)
            WSEL_8:  r = {v[7:0], 24'd0};
            WSEL_16: r = {v[15:0], 16'd0};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] align_lsb(input logic [CRC_W-1:0] v,
                                                   input logic [1:0]       wsel);
        logic [CRC_W-1:0] r;
        case (wsel)
            WSEL_8:  r = {24'd0, v[31:24]};
            WSEL_16: r = {16'd0, v[31:16]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Eight MSB-first division steps on an MSB-aligned remainder
    function automatic logic [CRC_W-1:0] crc_byte_step(input logic [CRC_W-1:0]  rem,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [CRC_W-1:0]  poly);
        logic [CRC_W-1:0] c;
        c = rem ^ {b, 24'd0};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/configurable_crc_engine.sv
// ----------------------------------------------------------------------------
// configurable_crc_engine: byte-serial CRC-8/16/32 with optional reflection
// Input register, byte update of the running remainder register, and a
// result register that carries the finished CRC of each message.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one message byte per word; last_byte closes
//   the message. m_valid/m_ready/m_data give one word per message: the CRC
//   in its low width bits, or all ones with config_error when the polynomial
//   masked to the width is zero.
//   cfg_wr_en/cfg_wr_index/cfg_wr_data write polynomial, width select and the
//   two reflection flags; write them only while no message is in flight.
//   Throughput is one byte per cycle while no last byte waits for the result
//   register. A byte is registered at acceptance and folded into the remainder
//   from the input register, where a last byte also loads the result register
//   that drives m_data. The eight-step XOR update between the input register
//   and the remainder register sets the clock period.
//   A stalled receiver holds the result; bytes that are not last keep
//   flowing, and a last byte waits in the input register until the result
//   register frees up.
//   Reset empties both registers, clears the remainder and loads the
//   register defaults (poly 0x31, 8 bits, both reflections on).
// ----------------------------------------------------------------------------
module configurable_crc_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ccrc_pkg::ccrc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ccrc_pkg::ccrc_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [ccrc_pkg::CRC_W-1:0]          cfg_wr_data
);
    import ccrc_pkg::*;

    logic [CRC_W-1:0] poly_reg;
    logic [1:0]       wsel_reg;
    logic             refl_in_reg;
    logic             refl_out_reg;

    logic             in_valid_reg;
    ccrc_in_t         in_word_reg;
    logic [CRC_W-1:0] rem_reg;
    logic [CRC_W-1:0] rem_next;
    logic             out_valid_reg;
    ccrc_out_t        out_word_reg;
    ccrc_out_t        out_word_next;

    logic             advance;
    logic [BYTE_W-1:0] byte_in;
    logic [CRC_W-1:0] poly_aligned;
    logic [CRC_W-1:0] crc_aligned;

    // A last byte needs a free result register; other bytes always move on
    assign advance = in_valid_reg
                     && (!in_word_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    always_comb begin
        byte_in      = refl_in_reg ? reverse_byte(in_word_reg.data_byte)
                                   : in_word_reg.data_byte;
        poly_aligned = align_msb(poly_reg, wsel_reg);
        crc_aligned  = crc_byte_step(align_msb(rem_reg, wsel_reg), byte_in, poly_aligned);
        rem_next     = in_word_reg.last_byte ? '0 : align_lsb(crc_aligned, wsel_reg);

        if (poly_aligned == '0) begin
            out_word_next.crc_value    = CRC_ALL_ONES;
            out_word_next.config_error = 1'b1;
        end else begin
            // reversing the MSB-aligned word lands the reflected CRC in the low bits
            out_word_next.crc_value    = refl_out_reg ? reverse_word(crc_aligned)
                                                      : align_lsb(crc_aligned, wsel_reg);
            out_word_next.config_error = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg      <= POLY_RESET;
            wsel_reg      <= WSEL_8;
            refl_in_reg   <= 1'b1;
            refl_out_reg  <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_POLYNOMIAL:     poly_reg     <= cfg_wr_data;
                    CFG_WIDTH_SELECT:   wsel_reg     <= cfg_wr_data[1:0];
                    CFG_REFLECT_INPUT:  refl_in_reg  <= cfg_wr_data[0];
                    CFG_REFLECT_OUTPUT: refl_out_reg <= cfg_wr_data[0];
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                rem_reg <= rem_next;
            end

            // drop the result once taken, load a fresh one on a last byte
            if (advance && in_word_reg.last_byte) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (advance && in_word_reg.last_byte) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule
